FILE: sv/sitc_pkg.sv
`default_nettype none

package sitc_pkg;

   localparam int INDEX_BITS_DEFAULT = 32;
   localparam int COORD_BITS         = 17;

endpackage

`default_nettype wire

FILE: sv/sitc_if.sv
`default_nettype none

interface sitc_req_if
   import sitc_pkg::*;
   #(parameter int INDEX_BITS = INDEX_BITS_DEFAULT)
   ();
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] spiral_index;

   modport source (output valid, output spiral_index, input ready);
   modport sink   (input valid, input spiral_index, output ready);
endinterface

interface sitc_rsp_if
   import sitc_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic                         bad_index;

   modport source (output valid, output coord_x, output coord_y, output bad_index,
                   input ready);
   modport sink   (input valid, input coord_x, input coord_y, input bad_index,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/sitc_root_cell.sv
`default_nettype none

module sitc_root_cell
   import sitc_pkg::*;
   #(
      parameter int ROOT_BITS = (INDEX_BITS_DEFAULT + 1) / 2,
      parameter int STEP      = 0
   )
   (
      input  wire logic                   clock,
      input  wire logic                   reset,
      input  wire logic                   up_valid,
      output logic                        up_ready,
      input  wire logic [ROOT_BITS+1:0]   up_rem,
      input  wire logic [ROOT_BITS-1:0]   up_root,
      input  wire logic [2*ROOT_BITS-1:0] up_rad,
      input  wire logic                   up_zero,
      output logic                        down_valid,
      input  wire logic                   down_ready,
      output logic [ROOT_BITS+1:0]        down_rem,
      output logic [ROOT_BITS-1:0]        down_root,
      output logic [2*ROOT_BITS-1:0]      down_rad,
      output logic                        down_zero
   );

   localparam int POS = 2 * (ROOT_BITS - 1 - STEP);

   logic                 valid_ff;
   logic                 valid_in;
   logic [ROOT_BITS+1:0] rem_ff;
   logic [ROOT_BITS+1:0] rem_in;
   logic [ROOT_BITS-1:0] root_ff;
   logic [ROOT_BITS-1:0] root_in;
   logic [2*ROOT_BITS-1:0] rad_ff;
   logic                 zero_ff;
   logic [ROOT_BITS+1:0] rem_shift;
   logic [ROOT_BITS+1:0] trial;
   logic                 fits;
   logic                 load;

   always_comb begin
      up_ready  = !valid_ff || down_ready;
      load      = up_valid && up_ready;
      valid_in  = up_ready ? up_valid : valid_ff;
      rem_shift = {up_rem[ROOT_BITS-1:0], up_rad[POS+1:POS]};
      trial     = {up_root, 2'b01};
      fits      = rem_shift >= trial;
      rem_in    = fits ? rem_shift - trial : rem_shift;
      root_in   = {up_root[ROOT_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= up_rad;
         zero_ff <= up_zero;
      end
   end

   assign down_valid = valid_ff;
   assign down_rem   = rem_ff;
   assign down_root  = root_ff;
   assign down_rad   = rad_ff;
   assign down_zero  = zero_ff;

endmodule

`default_nettype wire

FILE: sv/sitc_square_stage.sv
`default_nettype none

module sitc_square_stage
   import sitc_pkg::*;
   #(parameter int ROOT_BITS = (INDEX_BITS_DEFAULT + 1) / 2)
   (
      input  wire logic                   clock,
      input  wire logic                   reset,
      input  wire logic                   up_valid,
      output logic                        up_ready,
      input  wire logic [ROOT_BITS-1:0]   up_root,
      input  wire logic [2*ROOT_BITS-1:0] up_rad,
      input  wire logic                   up_zero,
      output logic                        down_valid,
      input  wire logic                   down_ready,
      output logic [ROOT_BITS-1:0]        down_ring,
      output logic [ROOT_BITS+2:0]        down_dist,
      output logic                        down_zero
   );

   localparam int TW = 2 * (ROOT_BITS + 1);
   localparam int DW = ROOT_BITS + 3;

   logic                 valid_ff;
   logic                 valid_in;
   logic [ROOT_BITS-1:0] ring_ff;
   logic [ROOT_BITS-1:0] ring_in;
   logic [DW-1:0]        dist_ff;
   logic [DW-1:0]        dist_in;
   logic                 zero_ff;
   logic [ROOT_BITS:0]   ceil_root;
   logic [ROOT_BITS:0]   odd_root;
   logic [TW-1:0]        odd_square;
   logic [TW-1:0]        index;
   logic [TW-1:0]        diff;
   logic                 load;

   always_comb begin
      up_ready   = !valid_ff || down_ready;
      load       = up_valid && up_ready;
      valid_in   = up_ready ? up_valid : valid_ff;
      ceil_root  = (ROOT_BITS + 1)'(up_root) + (ROOT_BITS + 1)'(1);
      odd_root   = ceil_root | (ROOT_BITS + 1)'(1);
      ring_in    = ceil_root[ROOT_BITS:1];
      odd_square = TW'(odd_root) * TW'(odd_root);
      index      = TW'(up_rad) + TW'(1);
      diff       = odd_square - index;
      dist_in    = diff[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         ring_ff <= ring_in;
         dist_ff <= dist_in;
         zero_ff <= up_zero;
      end
   end

   assign down_valid = valid_ff;
   assign down_ring  = ring_ff;
   assign down_dist  = dist_ff;
   assign down_zero  = zero_ff;

endmodule

`default_nettype wire

FILE: sv/sitc_side_stage.sv
`default_nettype none

module sitc_side_stage
   import sitc_pkg::*;
   #(parameter int ROOT_BITS = (INDEX_BITS_DEFAULT + 1) / 2)
   (
      input  wire logic                 clock,
      input  wire logic                 reset,
      input  wire logic                 up_valid,
      output logic                      up_ready,
      input  wire logic [ROOT_BITS-1:0] up_ring,
      input  wire logic [ROOT_BITS+2:0] up_dist,
      input  wire logic                 up_zero,
      sitc_rsp_if.source                rsp_if
   );

   localparam int DW = ROOT_BITS + 3;
   localparam int AW = (DW > COORD_BITS) ? DW : COORD_BITS;

   logic                  valid_ff;
   logic                  valid_in;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic                  bad_ff;
   logic [AW-1:0]         ring;
   logic [AW-1:0]         gap;
   logic [AW-1:0]         side1;
   logic [AW-1:0]         side2;
   logic [AW-1:0]         side3;
   logic [AW-1:0]         x_full;
   logic [AW-1:0]         y_full;
   logic                  load;

   always_comb begin
      up_ready = !valid_ff || rsp_if.ready;
      load     = up_valid && up_ready;
      valid_in = up_ready ? up_valid : valid_ff;
      ring     = AW'(up_ring);
      gap      = AW'(up_dist);
      side1    = ring << 1;
      side2    = ring << 2;
      side3    = side1 + side2;
      if (gap < side1) begin
         x_full = ring - gap;
         y_full = AW'(0) - ring;
      end else if (gap < side2) begin
         x_full = AW'(0) - ring;
         y_full = (AW'(0) - ring) + (gap - side1);
      end else if (gap < side3) begin
         x_full = (AW'(0) - ring) + (gap - side2);
         y_full = ring;
      end else begin
         x_full = ring;
         y_full = ring - (gap - side3);
      end
      if (up_zero) begin
         x_full = '0;
         y_full = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         x_ff   <= x_full[COORD_BITS-1:0];
         y_ff   <= y_full[COORD_BITS-1:0];
         bad_ff <= up_zero;
      end
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.coord_x   = signed'(x_ff);
   assign rsp_if.coord_y   = signed'(y_ff);
   assign rsp_if.bad_index = bad_ff;

endmodule

`default_nettype wire

FILE: sv/spiral_index_to_coordinate.sv
// Square spiral index to grid coordinate.
// req_if carries one 1-based spiral_index per item; rsp_if returns one item with
// the signed 17-bit coord_x, coord_y and bad_index. Index zero sets bad_index
// and gives (0,0); index one gives (0,0) without the flag.
// Both channels move an item on a clock edge where valid and ready are high.
// Stages: ROOT_BITS root cells with ROOT_BITS = (INDEX_BITS + 1) / 2, one per
// result bit of the integer square root of index - 1, one stage squaring the odd
// ring width, and one stage picking the side and registering the coordinate.
// Throughput: one item per cycle while rsp_if.ready stays high. Every stage
// holds its own valid bit and fills whenever it is empty or its neighbor moves
// on, so a stalled receiver stops only the stages that are full; bubbles are
// squeezed out and req_if.ready falls only once every stage holds an item.
// Reset (synchronous, active high) empties all stages; no item is lost or
// duplicated across a stall.
`default_nettype none

module spiral_index_to_coordinate
   import sitc_pkg::*;
   #(parameter int INDEX_BITS = INDEX_BITS_DEFAULT)
   (
      input wire logic clock,
      input wire logic reset,
      sitc_req_if.sink   req_if,
      sitc_rsp_if.source rsp_if
   );

   localparam int ROOT_BITS = (INDEX_BITS + 1) / 2;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int STAGES    = ROOT_BITS + 2;

   logic                  link_valid [ROOT_BITS+1];
   logic                  link_ready [ROOT_BITS+1];
   logic [ROOT_BITS+1:0]  link_rem   [ROOT_BITS+1];
   logic [ROOT_BITS-1:0]  link_root  [ROOT_BITS+1];
   logic [RAD_BITS-1:0]   link_rad   [ROOT_BITS+1];
   logic                  link_zero  [ROOT_BITS+1];
   logic [INDEX_BITS-1:0] index_dec;
   logic                  sq_valid;
   logic                  sq_ready;
   logic [ROOT_BITS-1:0]  sq_ring;
   logic [ROOT_BITS+2:0]  sq_dist;
   logic                  sq_zero;
   logic [STAGES-1:0]     stage_full;

   assign index_dec     = req_if.spiral_index - INDEX_BITS'(1);
   assign link_valid[0] = req_if.valid;
   assign req_if.ready  = link_ready[0];
   assign link_rem[0]   = '0;
   assign link_root[0]  = '0;
   assign link_rad[0]   = RAD_BITS'(index_dec);
   assign link_zero[0]  = req_if.spiral_index == '0;

   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
      sitc_root_cell #(.ROOT_BITS(ROOT_BITS), .STEP(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (link_valid[i]),
         .up_ready   (link_ready[i]),
         .up_rem     (link_rem[i]),
         .up_root    (link_root[i]),
         .up_rad     (link_rad[i]),
         .up_zero    (link_zero[i]),
         .down_valid (link_valid[i+1]),
         .down_ready (link_ready[i+1]),
         .down_rem   (link_rem[i+1]),
         .down_root  (link_root[i+1]),
         .down_rad   (link_rad[i+1]),
         .down_zero  (link_zero[i+1])
      );
      assign stage_full[i] = link_valid[i+1];
   end

   sitc_square_stage #(.ROOT_BITS(ROOT_BITS)) u_square (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (link_valid[ROOT_BITS]),
      .up_ready   (link_ready[ROOT_BITS]),
      .up_root    (link_root[ROOT_BITS]),
      .up_rad     (link_rad[ROOT_BITS]),
      .up_zero    (link_zero[ROOT_BITS]),
      .down_valid (sq_valid),
      .down_ready (sq_ready),
      .down_ring  (sq_ring),
      .down_dist  (sq_dist),
      .down_zero  (sq_zero)
   );

   sitc_side_stage #(.ROOT_BITS(ROOT_BITS)) u_side (
      .clock    (clock),
      .reset    (reset),
      .up_valid (sq_valid),
      .up_ready (sq_ready),
      .up_ring  (sq_ring),
      .up_dist  (sq_dist),
      .up_zero  (sq_zero),
      .rsp_if   (rsp_if)
   );

   assign stage_full[ROOT_BITS]   = sq_valid;
   assign stage_full[ROOT_BITS+1] = rsp_if.valid;

   a_bad_gives_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.bad_index |-> rsp_if.coord_x == '0 && rsp_if.coord_y == '0)
      else $error("zero index item carries a nonzero coordinate");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> !rsp_if.valid && stage_full == '0)
      else $error("pipeline holds an item right after reset");

   a_ready_needs_room : assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> ($countones(stage_full) < STAGES) || rsp_if.ready)
      else $error("input taken while every stage is full and stalled");

endmodule

`default_nettype wire

FILE: tb/sv/spiral_index_to_coordinate_tb.sv
`default_nettype none

module spiral_index_to_coordinate_tb
   import sitc_pkg::*;
   ;

   localparam int INDEX_BITS = INDEX_BITS_DEFAULT;
   localparam int LATENCY    = (INDEX_BITS + 1) / 2 + 2;
   localparam int HALF_CLOCK = 2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         bad;
   } coord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sitc_req_if #(.INDEX_BITS(INDEX_BITS)) req_if ();
   sitc_rsp_if rsp_if ();

   spiral_index_to_coordinate #(.INDEX_BITS(INDEX_BITS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   coord_type pending_coords [$];
   int        mismatch_count = 0;
   int        send_idle_pct  = 0;
   int        recv_idle_pct  = 0;

   always #HALF_CLOCK clock = ~clock;

   function automatic coord_type spiral_position(input logic [INDEX_BITS-1:0] idx);
      coord_type              c;
      longint unsigned        n;
      longint unsigned        root;
      longint unsigned        probe;
      longint unsigned        ring_w;
      longint signed          k;
      longint signed          side;
      longint signed          d;
      longint signed          x;
      longint signed          y;
      c.bad = (idx == '0);
      x = 0;
      y = 0;
      if (!c.bad) begin
         n    = {32'd0, idx} - 64'd1;
         root = 0;
         for (int b = 16; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= n) root = probe;
         end
         ring_w = root + 1;
         if (!ring_w[0]) ring_w = ring_w + 1;
         k    = longint'((ring_w - 1) >> 1);
         side = 2 * k;
         d    = longint'(ring_w * ring_w - {32'd0, idx});
         if (d < side) begin
            x = k - d;
            y = -k;
         end else if (d < 2 * side) begin
            x = -k;
            y = -k + (d - side);
         end else if (d < 3 * side) begin
            x = -k + (d - 2 * side);
            y = k;
         end else begin
            x = k;
            y = k - (d - 3 * side);
         end
      end
      c.x = x[COORD_BITS-1:0];
      c.y = y[COORD_BITS-1:0];
      return c;
   endfunction

   // bias toward ring corners, where the side selection changes
   function automatic logic [INDEX_BITS-1:0] pick_index();
      longint unsigned k;
      longint unsigned ring_w;
      longint unsigned base;
      int              sel;
      sel = $urandom_range(99);
      if (sel < 40) begin
         k      = ($urandom_range(99) < 70) ? $urandom_range(40) : $urandom_range(32767);
         ring_w = 2 * k + 1;
         base   = ring_w * ring_w - $urandom_range(4) * 2 * k;
         return INDEX_BITS'(base + $urandom_range(2) - 1);
      end else if (sel < 70) begin
         return $urandom;
      end else if (sel < 90) begin
         return $urandom_range(300);
      end else begin
         return $urandom | 32'hF000_0000;
      end
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      if (mismatch_count < 100)
         $display("%0t: %s mismatch: got %0d, want %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic send_index(input logic [INDEX_BITS-1:0] idx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid        <= 1'b1;
      req_if.spiral_index <= idx;
      do @(posedge clock); while (!req_if.ready);
      pending_coords = {pending_coords, spiral_position(idx)};
      @(negedge clock);
   endtask

   task automatic hold_sender();
      req_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      coord_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_coords.size() == 0) begin
            report_mismatch("unexpected item, coord_x", rsp_if.coord_x, 0);
         end else begin
            want = pending_coords.pop_front();
            if (rsp_if.coord_x !== want.x) report_mismatch("coord_x", rsp_if.coord_x, want.x);
            if (rsp_if.coord_y !== want.y) report_mismatch("coord_y", rsp_if.coord_y, want.y);
            if (rsp_if.bad_index !== want.bad)
               report_mismatch("bad_index", rsp_if.bad_index, want.bad);
         end
      end
   end

   task automatic test_special_indices();
      logic [INDEX_BITS-1:0] cases [$];
      cases = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
                32'd10, 32'd24, 32'd25, 32'd26, 32'd49, 32'd50,
                32'hFFFE_0001, 32'hFFFE_0002, 32'hFFFE_0000,
                32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                32'h5555_5555, 32'hAAAA_AAAA};
      foreach (cases[i]) send_index(cases[i]);
   endtask

   task automatic test_ring_boundaries(input int count);
      longint unsigned k;
      longint unsigned ring_w;
      repeat (count) begin
         k      = $urandom_range(32767);
         ring_w = 2 * k + 1;
         send_index(INDEX_BITS'(ring_w * ring_w - $urandom_range(4) * 2 * k
                                + $urandom_range(2) - 1));
      end
   endtask

   task automatic test_random_indices(input int count);
      repeat (count) send_index(pick_index());
   endtask

   task automatic test_drain_pause(input int bursts);
      repeat (bursts) begin
         repeat ($urandom_range(1, 30)) send_index(pick_index());
         hold_sender();
         wait (pending_coords.size() == 0);
         @(negedge clock);
      end
   endtask

   initial begin
      req_if.valid        = 1'b0;
      req_if.spiral_index = '0;
      rsp_if.ready        = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 9;
      recv_idle_pct = 50;
      test_special_indices();
      test_ring_boundaries(200);
      test_random_indices(250);

      send_idle_pct = 50;
      recv_idle_pct = 9;
      test_random_indices(350);
      test_drain_pause(5);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_ring_boundaries(100);
      test_random_indices(300);

      hold_sender();
      wait (pending_coords.size() == 0);
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(2 * HALF_CLOCK * 200000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
